@@ design/lmcr_pkg.sv @@
package lmcr_pkg;

  localparam int unsigned PW_BYTES = 14;
  localparam int unsigned N_ROUNDS = 16;
  localparam int unsigned N_STAGES = 2 * N_ROUNDS + 3;

  localparam logic [63:0] MAGIC_BLOCK = 64'h4B47_5321_4023_2425;
  localparam logic [7:0]  CASE_BIT    = 8'h20;

  typedef struct packed {
    logic [31:0] l;
    logic [31:0] r;
    logic [27:0] c;
    logic [27:0] d;
  } lane_t;

  localparam logic [6:0] TAB_IP [64] = '{
    58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
  localparam logic [6:0] TAB_FP [64] = '{
    40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
  localparam logic [5:0] TAB_E [48] = '{
    32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
    16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
  localparam logic [5:0] TAB_P [32] = '{
    16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
  localparam logic [6:0] TAB_PC1 [56] = '{
    57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,60,52,44,36,
    63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,29,21,13,5,28,20,12,4};
  localparam logic [5:0] TAB_PC2 [48] = '{
    14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
    41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
  localparam logic [3:0] SBOX [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  function automatic logic [63:0] perm_ip(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(TAB_IP[i])];
    return r;
  endfunction

  function automatic logic [63:0] perm_fp(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(TAB_FP[i])];
    return r;
  endfunction

  function automatic logic [47:0] perm_e(input logic [31:0] v);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) r[47-i] = v[32-int'(TAB_E[i])];
    return r;
  endfunction

  function automatic logic [31:0] perm_p(input logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) r[31-i] = v[32-int'(TAB_P[i])];
    return r;
  endfunction

  function automatic logic [47:0] perm_pc2(input logic [55:0] v);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) r[47-i] = v[56-int'(TAB_PC2[i])];
    return r;
  endfunction

  function automatic logic [31:0] sbox_all(input logic [47:0] x);
    logic [31:0] s;
    logic [5:0]  b;
    for (int j = 0; j < 8; j++) begin
      b = x[47-6*j -: 6];
      s[31-4*j -: 4] = SBOX[j][{b[5], b[0], b[4:1]}];
    end
    return s;
  endfunction

  // Spread 7 key bits per byte (parity slot zero), then PC1.
  function automatic logic [55:0] key_cd(input logic [55:0] k);
    logic [63:0] k64;
    logic [55:0] r;
    for (int i = 0; i < 8; i++) k64[63-8*i -: 8] = {k[55-7*i -: 7], 1'b0};
    for (int i = 0; i < 56; i++) r[55-i] = k64[64-int'(TAB_PC1[i])];
    return r;
  endfunction

  function automatic lane_t lane_init(input logic [55:0] key, input logic [63:0] blk);
    lane_t       ln;
    logic [63:0] lr;
    logic [55:0] cd;
    lr = perm_ip(blk);
    cd = key_cd(key);
    ln.l = lr[63:32];
    ln.r = lr[31:0];
    ln.c = cd[55:28];
    ln.d = cd[27:0];
    return ln;
  endfunction

  function automatic logic [63:0] lane_final(input lane_t ln);
    return perm_fp({ln.r, ln.l});
  endfunction

  // Truncate at the first zero byte and upper-case a-z.
  function automatic logic [111:0] pw_norm(input logic [111:0] pw);
    logic [111:0] r;
    logic [7:0]   b;
    logic         ended;
    ended = 1'b0;
    for (int i = 0; i < PW_BYTES; i++) begin
      b = pw[111-8*i -: 8];
      if (b == 8'h00) ended = 1'b1;
      if (ended) b = 8'h00;
      else if (b >= 8'h61 && b <= 8'h7A) b = b ^ CASE_BIT;
      r[111-8*i -: 8] = b;
    end
    return r;
  endfunction

endpackage

@@ design/lmcr_round.sv @@
module lmcr_round (
  input  logic           clk,
  input  logic           adv,
  input  logic           rot2,
  input  lmcr_pkg::lane_t lane_in,
  output lmcr_pkg::lane_t lane_out
);
  import lmcr_pkg::*;

  lane_t       lane_r;
  lane_t       lane_nxt;
  logic [27:0] c_rot;
  logic [27:0] d_rot;
  logic [31:0] f_val;

  always_comb begin
    c_rot = rot2 ? {lane_in.c[25:0], lane_in.c[27:26]} : {lane_in.c[26:0], lane_in.c[27]};
    d_rot = rot2 ? {lane_in.d[25:0], lane_in.d[27:26]} : {lane_in.d[26:0], lane_in.d[27]};
    f_val = perm_p(sbox_all(perm_e(lane_in.r) ^ perm_pc2({c_rot, d_rot})));
    lane_nxt.l = lane_in.r;
    lane_nxt.r = lane_in.l ^ f_val;
    lane_nxt.c = c_rot;
    lane_nxt.d = d_rot;
  end

  always_ff @(posedge clk) begin
    if (adv) lane_r <= lane_nxt;
  end

  assign lane_out = lane_r;
endmodule

@@ design/lm_challenge_response.sv @@
// Pipeline registers, in order: normalize, 16 hash rounds, key split,
// 16 response rounds, output register.
// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// Reset (rst_n low, synchronous): clear all stage valids and the challenge.
module lm_challenge_response (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [55:0] in_password_front,
  input  logic [55:0] in_password_back,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_server_challenge,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_response_first,
  output logic [63:0] out_response_second,
  output logic [63:0] out_response_third
);
  import lmcr_pkg::*;

  logic                adv;
  logic [N_STAGES-1:0] vld_r;
  logic [N_STAGES-1:0] vld_nxt;
  logic [63:0]         chal_r;
  logic [111:0]        pw_r;
  logic [55:0]         key1_r, key2_r, key3_r;
  logic [63:0]         hash1, hash2;
  logic [63:0]         resp1_r, resp2_r, resp3_r;

  // Hash chain: two lanes, response chain: three lanes.
  lane_t hl [N_ROUNDS+1][2];
  lane_t ql [N_ROUNDS+1][3];

  // Advance everything together; hold when the output is stalled.
  assign adv       = !vld_r[N_STAGES-1] || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;
  assign out_valid = vld_r[N_STAGES-1];

  assign vld_nxt = {vld_r[N_STAGES-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      chal_r <= '0;
    end else begin
      if (adv) vld_r <= vld_nxt;
      if (cfg_valid) chal_r <= cfg_server_challenge;
    end
  end

  // Stage 0: normalize the password bytes.
  always_ff @(posedge clk) begin
    if (adv) pw_r <= pw_norm({in_password_front, in_password_back});
  end

  // Each half keys DES over the magic block.
  assign hl[0][0] = lane_init(pw_r[111:56], MAGIC_BLOCK);
  assign hl[0][1] = lane_init(pw_r[55:0], MAGIC_BLOCK);

  // One cell per round and lane; rounds 1, 2, 9 and 16 rotate by one bit.
  for (genvar i = 0; i < N_ROUNDS; i++) begin : g_hash
    for (genvar j = 0; j < 2; j++) begin : g_lane
      lmcr_round u_round (
        .clk     (clk),
        .adv     (adv),
        .rot2    (!(i == 0 || i == 1 || i == 8 || i == N_ROUNDS-1)),
        .lane_in (hl[i][j]),
        .lane_out(hl[i+1][j])
      );
    end
  end

  // Split the 16-byte hash, zero padded to 21, into three keys.
  assign hash1 = lane_final(hl[N_ROUNDS][0]);
  assign hash2 = lane_final(hl[N_ROUNDS][1]);

  always_ff @(posedge clk) begin
    if (adv) begin
      key1_r <= hash1[63:8];
      key2_r <= {hash1[7:0], hash2[63:16]};
      key3_r <= {hash2[15:0], 40'h0};
    end
  end

  // The user must rewrite the challenge only while idle (the block does not enforce it), so read it live here.
  assign ql[0][0] = lane_init(key1_r, chal_r);
  assign ql[0][1] = lane_init(key2_r, chal_r);
  assign ql[0][2] = lane_init(key3_r, chal_r);

  for (genvar i = 0; i < N_ROUNDS; i++) begin : g_resp
    for (genvar j = 0; j < 3; j++) begin : g_lane
      lmcr_round u_round (
        .clk     (clk),
        .adv     (adv),
        .rot2    (!(i == 0 || i == 1 || i == 8 || i == N_ROUNDS-1)),
        .lane_in (ql[i][j]),
        .lane_out(ql[i+1][j])
      );
    end
  end

  // Output register: final permutation of each lane.
  always_ff @(posedge clk) begin
    if (adv) begin
      resp1_r <= lane_final(ql[N_ROUNDS][0]);
      resp2_r <= lane_final(ql[N_ROUNDS][1]);
      resp3_r <= lane_final(ql[N_ROUNDS][2]);
    end
  end

  assign out_response_first  = resp1_r;
  assign out_response_second = resp2_r;
  assign out_response_third  = resp3_r;
endmodule

@@ design/lmcr_checker.sv @@
module lmcr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        cfg_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_response_first
);

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_response_first))
    else $error("result dropped or changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // Input is refused only behind a stalled result.
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config write refused");

endmodule

bind lm_challenge_response lmcr_checker u_lmcr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .cfg_ready         (cfg_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_response_first(out_response_first)
);
